/* hw/rtl/fle_pkg.sv */
`timescale 1ns / 1ps

package fle_pkg;

    localparam int DEF_SLOTS     = 16;
    localparam int DEF_ITEM_BITS = 16;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_TOUCH  = 2'd2;
    localparam logic [1:0] MODE_EVICT  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_DROP,
        ACT_MOVE
    } act_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] item_id;
        logic [3:0]  handle;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_handle;
        logic [15:0] victim_item;
    } rsp_t;

    // broadcast from the top to every cell
    typedef struct packed {
        act_t       act;
        logic [1:0] mode;
    } cell_ctrl_t;

    // flags rippled from cell to cell
    typedef struct packed {
        logic free_below;
        logic found;
    } chain_t;

endpackage

/* hw/rtl/fle_cell.sv */
`timescale 1ns / 1ps

module fle_cell #(
    parameter int SLOTS     = 16,
    parameter int ITEM_BITS = 16,
    parameter int IDX       = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fle_pkg::cell_ctrl_t       ctrl,
    input  logic [3:0]                handle,
    input  logic [ITEM_BITS-1:0]      item_in,
    input  logic [$clog2(SLOTS)-1:0]  base_rank,
    input  logic [$clog2(SLOTS)-1:0]  new_rank,
    input  fle_pkg::chain_t           chain_in,
    output fle_pkg::chain_t           chain_out,
    input  logic [$clog2(SLOTS)-1:0]  rank_in,
    output logic [$clog2(SLOTS)-1:0]  rank_out,
    input  logic [$clog2(SLOTS)-1:0]  slot_in,
    output logic [$clog2(SLOTS)-1:0]  slot_out,
    input  logic [ITEM_BITS-1:0]      sel_item_in,
    output logic [ITEM_BITS-1:0]      sel_item_out,
    output logic                      vld
);
    import fle_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic                 vld_reg, vld_next;
    logic [IW-1:0]        rank_reg, rank_next;
    logic [ITEM_BITS-1:0] item_reg, item_next;
    logic                 lowest_free;
    logic                 hit;
    logic                 sel;
    logic                 younger;

    assign lowest_free = !vld_reg && !chain_in.free_below;
    assign hit         = vld_reg && (32'(handle) == IDX);
    assign younger     = vld_reg && (rank_reg > base_rank);

    always_comb
    begin
        case (ctrl.mode)
            MODE_ADD:    sel = lowest_free;
            MODE_REMOVE: sel = hit;
            MODE_TOUCH:  sel = hit;
            MODE_EVICT:  sel = vld_reg && (rank_reg == '0);
            default:     sel = 1'b0;
        endcase
    end

    assign chain_out.free_below = chain_in.free_below || !vld_reg;
    assign chain_out.found      = chain_in.found || sel;
    assign rank_out     = rank_in | (sel ? rank_reg : '0);
    assign slot_out     = slot_in | (sel ? IW'(IDX) : '0);
    assign sel_item_out = sel_item_in | (sel ? item_reg : '0);
    assign vld          = vld_reg;

    always_comb
    begin
        vld_next  = vld_reg;
        rank_next = rank_reg;
        item_next = item_reg;
        case (ctrl.act)
            ACT_INSERT:
            begin
                if (sel)
                begin
                    vld_next  = 1'b1;
                    rank_next = new_rank;
                    item_next = item_in;
                end
            end
            ACT_DROP:
            begin
                if (sel)
                    vld_next = 1'b0;
                else if (younger)
                    rank_next = rank_reg - 1'b1;
            end
            ACT_MOVE:
            begin
                if (sel)
                    rank_next = new_rank;
                else if (younger)
                    rank_next = rank_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            rank_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

/* hw/rtl/fifo_lru_eviction_order_top.sv */
`timescale 1ns / 1ps

// channel   | signals                        | transaction
// ----------+--------------------------------+-------------------------------
// command   | start, busy, request           | start high while busy low
// result    | done, result                   | done high, one cycle, no stall
// config    | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// Each command is latched first; then, in the execute state, every slot cell
// compares against the broadcast command and updates its age rank.
// The result strobe comes the cycle after; start is taken again in that cycle.
// Reset clears all valid bits at once, so no clearing pass follows it.
// The result side cannot stall; cfg_ready is always high.
module fifo_lru_eviction_order_top #(
    parameter int SLOTS     = fle_pkg::DEF_SLOTS,
    parameter int ITEM_BITS = fle_pkg::DEF_ITEM_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fle_pkg::cmd_t request,
    output logic          done,
    output fle_pkg::rsp_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);
    import fle_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    state_t          state_reg, state_next;
    cmd_t            cmd_reg;
    logic            policy_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            done_reg;
    rsp_t            rsp_reg, rsp_next;

    logic            accept;
    logic            exec_en;
    cell_ctrl_t      ctrl;
    act_t            act;
    logic [IW-1:0]   new_rank;
    logic [SLOTS-1:0] vld_vec;

    chain_t               chain_w    [SLOTS+1];
    logic [IW-1:0]        rank_w     [SLOTS+1];
    logic [IW-1:0]        slot_w     [SLOTS+1];
    logic [ITEM_BITS-1:0] sel_item_w [SLOTS+1];

    assign chain_w[0]    = '0;
    assign rank_w[0]     = '0;
    assign slot_w[0]     = '0;
    assign sel_item_w[0] = '0;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
            S_EXEC:
            begin
                busy    = 1'b1;
                exec_en = 1'b1;
            end
            default:
            begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    // decide from the chain flags and the entry count; the flags never depend on act
    always_comb
    begin
        act      = ACT_NONE;
        rsp_next = '0;
        case (cmd_reg.mode)
            MODE_ADD:
            begin
                if (chain_w[SLOTS].free_below)
                begin
                    act                    = ACT_INSERT;
                    rsp_next.result_handle = 4'(slot_w[SLOTS]);
                end
                else
                    rsp_next.status = ST_FULL;
            end
            MODE_REMOVE:
            begin
                if (chain_w[SLOTS].found)
                    act = ACT_DROP;
                else
                    rsp_next.status = ST_BAD_HANDLE;
            end
            MODE_TOUCH:
            begin
                if (!chain_w[SLOTS].found)
                    rsp_next.status = ST_BAD_HANDLE;
                else if (policy_reg)
                    act = ACT_MOVE;
            end
            MODE_EVICT:
            begin
                if (count_reg != '0)
                begin
                    act                    = ACT_DROP;
                    rsp_next.result_handle = 4'(slot_w[SLOTS]);
                    rsp_next.victim_item   = 16'(sel_item_w[SLOTS]);
                end
                else
                    rsp_next.status = ST_EMPTY;
            end
            default:
            begin
            end
        endcase
        if (!exec_en)
            act = ACT_NONE;
    end

    assign ctrl.act  = act;
    assign ctrl.mode = cmd_reg.mode;

    // insert lands at the newest rank; a moved entry takes count - 1
    assign new_rank = (act == ACT_MOVE) ? IW'(count_reg - 1'b1) : IW'(count_reg);

    always_comb
    begin
        case (act)
            ACT_INSERT: count_next = count_reg + 1'b1;
            ACT_DROP:   count_next = count_reg - 1'b1;
            default:    count_next = count_reg;
        endcase
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        fle_cell #(
            .SLOTS     (SLOTS),
            .ITEM_BITS (ITEM_BITS),
            .IDX       (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .handle       (cmd_reg.handle),
            .item_in      (ITEM_BITS'(cmd_reg.item_id)),
            .base_rank    (rank_w[SLOTS]),
            .new_rank     (new_rank),
            .chain_in     (chain_w[i]),
            .chain_out    (chain_w[i+1]),
            .rank_in      (rank_w[i]),
            .rank_out     (rank_w[i+1]),
            .slot_in      (slot_w[i]),
            .slot_out     (slot_w[i+1]),
            .sel_item_in  (sel_item_w[i]),
            .sel_item_out (sel_item_w[i+1]),
            .vld          (vld_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            policy_reg <= 1'b0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= exec_en;
            if (cfg_valid && cfg_ready)
                policy_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= request;
        if (exec_en)
            rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= SLOTS)
        else $error("entry count above slot count");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(vld_vec))
        else $error("entry count differs from valid cells");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without execution cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && done_reg == 1'b0))
        else $error("accepted command not executing");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import fle_pkg::*;

    localparam int         NSLOT = DEF_SLOTS;
    localparam logic [4:0] NIL   = 5'(NSLOT);
    localparam int         LIMIT = 200000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic start     = 1'b0;
    logic busy;
    cmd_t request   = '0;
    logic done;
    rsp_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    fifo_lru_eviction_order_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // shadow of the replacement order: doubly linked list, oldest to newest
    logic [4:0]  nxt_of    [NSLOT];
    logic [4:0]  prv_of    [NSLOT];
    logic [15:0] slot_item [NSLOT];
    logic        slot_used [NSLOT];
    logic [4:0]  oldest;
    logic [4:0]  newest;
    logic        lru_on;

    cmd_t pending      [$];
    rsp_t rsp_expected [$];
    int   n_queued   = 0;
    int   n_taken    = 0;
    int   cfg_writes = 0;
    int   errors     = 0;
    int   cycles     = 0;
    int   gap_left   = 0;
    logic cmd_fired  = 1'b0;
    logic no_idle    = 1'b0;

    function automatic void unlink_entry(logic [4:0] s);
        logic [4:0] p;
        logic [4:0] n;
        p = prv_of[s];
        n = nxt_of[s];
        if (p != NIL) nxt_of[p] = n;
        else oldest = n;
        if (n != NIL) prv_of[n] = p;
        else newest = p;
        nxt_of[s] = NIL;
        prv_of[s] = NIL;
    endfunction

    function automatic void link_newest(logic [4:0] s);
        prv_of[s] = newest;
        nxt_of[s] = NIL;
        if (newest != NIL) nxt_of[newest] = s;
        else oldest = s;
        newest = s;
    endfunction

    function automatic rsp_t order_list_apply(cmd_t c);
        rsp_t       r;
        int         pick;
        int         i;
        logic [4:0] v;
        r = '0;
        r.status = ST_OK;
        pick = -1;
        case (c.mode)
            MODE_ADD: begin
                // lowest free slot wins
                for (i = NSLOT - 1; i >= 0; i--)
                    if (!slot_used[i]) pick = i;
                if (pick < 0) begin
                    r.status = ST_FULL;
                end
                else begin
                    v = 5'(pick);
                    slot_item[v] = c.item_id;
                    slot_used[v] = 1'b1;
                    link_newest(v);
                    r.result_handle = v[3:0];
                end
            end
            MODE_EVICT: begin
                if (oldest == NIL) begin
                    r.status = ST_EMPTY;
                end
                else begin
                    v = oldest;
                    r.result_handle = v[3:0];
                    r.victim_item = slot_item[v];
                    unlink_entry(v);
                    slot_used[v] = 1'b0;
                end
            end
            default: begin
                v = {1'b0, c.handle};
                if (!slot_used[v]) begin
                    r.status = ST_BAD_HANDLE;
                end
                else if (c.mode == MODE_REMOVE) begin
                    unlink_entry(v);
                    slot_used[v] = 1'b0;
                end
                else if (lru_on) begin
                    unlink_entry(v);
                    link_newest(v);
                end
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // command driver: holds start until the transaction is taken
    always @(negedge clk) begin
        if (rst_n && !(start && !cmd_fired)) begin
            if (start) gap_left = draw_gap();
            if (gap_left == 0 && pending.size() != 0) begin
                request <= pending.pop_front();
                start   <= 1'b1;
            end
            else begin
                start <= 1'b0;
                if (gap_left != 0) gap_left--;
            end
        end
    end

    // predictor and result checker
    always @(posedge clk) begin
        rsp_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("fifo_lru_eviction_order_top verification failed");
            $finish;
        end
        else if (rst_n) begin
            if (done) begin
                if (rsp_expected.size() == 0) begin
                    $error("result strobe with no command outstanding");
                    errors++;
                end
                else begin
                    want = rsp_expected.pop_front();
                    if (result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        errors++;
                    end
                    if (result.result_handle !== want.result_handle) begin
                        $error("result_handle: expected %0d, got %0d",
                               want.result_handle, result.result_handle);
                        errors++;
                    end
                    if (result.victim_item !== want.victim_item) begin
                        $error("victim_item: expected %h, got %h",
                               want.victim_item, result.victim_item);
                        errors++;
                    end
                end
            end
            cmd_fired <= start && !busy;
            if (start && !busy) begin
                rsp_expected.push_back(order_list_apply(request));
                n_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                lru_on = cfg_data;
                cfg_writes++;
            end
        end
    end

    task automatic send(logic [1:0] m, logic [15:0] id, logic [3:0] h);
        cmd_t c;
        c.mode    = m;
        c.item_id = id;
        c.handle  = h;
        pending.push_back(c);
        n_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (n_taken != n_queued || rsp_expected.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_policy(logic v);
        int seen;
        seen = cfg_writes;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(negedge clk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    // bursts of adds fill the store, bursts of evicts drain it, the rest is mixed
    task automatic random_phase(int n_items);
        int         left;
        int         kind;
        int         run;
        int         r;
        int         k;
        logic [1:0] m;
        @(posedge clk);
        left = n_items;
        while (left > 0) begin
            kind = $urandom_range(9);
            run = $urandom_range(1, 18);
            if (run > left) run = left;
            no_idle = ($urandom_range(7) == 0);
            for (k = 0; k < run; k++) begin
                if (kind < 3) begin
                    m = MODE_ADD;
                end
                else if (kind < 5) begin
                    m = MODE_EVICT;
                end
                else if (kind < 9) begin
                    r = $urandom_range(99);
                    if (r < 30) m = MODE_ADD;
                    else if (r < 50) m = MODE_REMOVE;
                    else if (r < 80) m = MODE_TOUCH;
                    else m = MODE_EVICT;
                end
                else begin
                    m = 2'($urandom);
                end
                send(m, 16'($urandom), 4'($urandom));
            end
            left -= run;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int i;
        for (i = 0; i < NSLOT; i++) begin
            nxt_of[i]    = NIL;
            prv_of[i]    = NIL;
            slot_item[i] = '0;
            slot_used[i] = 1'b0;
        end
        oldest = NIL;
        newest = NIL;
        lru_on = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // FIFO after reset: empty, bad handles, reuse of the lowest slot, fill to full
        @(posedge clk);
        send(MODE_EVICT, 16'h0000, 4'd0);
        send(MODE_REMOVE, 16'hffff, 4'd0);
        send(MODE_TOUCH, 16'h0000, 4'd15);
        send(MODE_ADD, 16'h0000, 4'd0);
        send(MODE_ADD, 16'hffff, 4'd15);
        send(MODE_ADD, 16'h5a5a, 4'd0);
        send(MODE_TOUCH, 16'h0000, 4'd1);
        send(MODE_REMOVE, 16'h0000, 4'd0);
        send(MODE_ADD, 16'h1234, 4'd0);
        send(MODE_EVICT, 16'hffff, 4'd15);
        for (i = 0; i < 14; i++)
            send(MODE_ADD, 16'($urandom), 4'($urandom));
        send(MODE_ADD, 16'hffff, 4'd0);
        send(MODE_REMOVE, 16'h0000, 4'd15);
        send(MODE_TOUCH, 16'h0000, 4'd15);
        wait_idle();

        // switch to LRU with entries held; order stays as it was
        write_policy(1'b1);
        @(posedge clk);
        send(MODE_TOUCH, 16'h0000, 4'd2);
        send(MODE_TOUCH, 16'h0000, 4'd2);
        send(MODE_TOUCH, 16'h0000, 4'd7);
        send(MODE_EVICT, 16'h0000, 4'd0);
        send(MODE_EVICT, 16'h0000, 4'd0);
        send(MODE_EVICT, 16'h0000, 4'd0);
        random_phase(180);
        wait_idle();

        write_policy(1'b0);
        random_phase(200);
        wait_idle();

        write_policy(1'b1);
        random_phase(200);
        wait_idle();

        write_policy(1'b1);
        random_phase(170);
        wait_idle();
        repeat (5) @(negedge clk);

        if (errors == 0)
            $display("fifo_lru_eviction_order_top verification clean");
        else
            $display("fifo_lru_eviction_order_top verification failed");
        $finish;
    end

endmodule

/* fifo_lru_eviction_order_top.f */
hw/rtl/fle_pkg.sv
hw/rtl/fle_cell.sv
hw/rtl/fifo_lru_eviction_order_top.sv
tb/testbench.sv
